>>> src/rde_pkg.sv
// ============================================================================
// rde_pkg - shared types and constants for the radix digit emitter
// Sizes, character codes, queue entry and alphabet status types, and the
// alphabet byte helpers used by the front and back modules.
// ============================================================================
package rde_pkg;

    // sizes
    localparam int MAX_DIGITS   = 32;
    localparam int NUMBER_WIDTH = 32;
    localparam int MAX_ALPHABET = 62;

    localparam int CFG_W       = 64;
    localparam int ALPHA_WORDS = 8;
    localparam int CFG_IDX_W   = $clog2(ALPHA_WORDS);
    localparam int ALPHA_BYTES = ALPHA_WORDS * CFG_W / 8;
    localparam int ALPHA_IDX_W = $clog2(ALPHA_BYTES);

    localparam int RADIX_W   = $clog2(MAX_ALPHABET + 1);
    localparam int DIGIT_W   = $clog2(MAX_ALPHABET);
    localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
    localparam int CHAR_W    = 7;

    // divider retires this many quotient bits per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (NUMBER_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_PAD_W = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int ALNUM_COUNT  = 62;
    localparam int ALNUM_CODE_W = $clog2(ALNUM_COUNT);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    localparam logic [7:0] LO_CODE_BASE = 8'd10;
    localparam logic [7:0] UP_CODE_BASE = 8'd36;

    typedef logic [ALPHA_BYTES*8-1:0] rde_alpha_bytes_t;

    // alphabet status from the front
    typedef struct packed {
        logic             valid;
        logic [RADIX_W-1:0] radix;
        rde_alpha_bytes_t bytes;
    } rde_alpha_t;

    // classified item in the queue
    typedef struct packed {
        logic                    neg;
        logic [NUMBER_WIDTH-1:0] mag;
    } rde_item_t;

    // back status
    typedef struct packed {
        logic busy;
    } rde_back_status_t;

    function automatic logic [7:0] alpha_byte(input rde_alpha_bytes_t a,
                                              input logic [ALPHA_IDX_W-1:0] k);
        return a[8*k +: 8];
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return c inside {[CHAR_0:CHAR_9], [CHAR_LO_A:CHAR_LO_Z], [CHAR_UP_A:CHAR_UP_Z]};
    endfunction

    // dense code 0..61 of an alphanumeric character
    function automatic logic [ALNUM_CODE_W-1:0] alnum_code(input logic [7:0] c);
        logic [7:0] d;
        if (c inside {[CHAR_0:CHAR_9]}) begin
            d = c - CHAR_0;
        end else if (c inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
            d = c - CHAR_LO_A + LO_CODE_BASE;
        end else begin
            d = c - CHAR_UP_A + UP_CODE_BASE;
        end
        return d[ALNUM_CODE_W-1:0];
    endfunction

endpackage

>>> src/radix_digit_emitter_core.sv
// ============================================================================
// radix_digit_emitter_core - signed integer to text in a configured radix
// Top level: front (alphabet check, classify), queue, back (divide, emit).
// ============================================================================
// Usage:
//   cfg_we/cfg_index/cfg_wdata write alphabet word 0..7 (byte k of word w is
//   character 8w+k; a zero byte ends the alphabet). Each write restarts an
//   alphabet check that walks one byte per cycle up to the terminator; s_ready
//   stays low meanwhile. Write config only with the block idle.
//   s_valid/s_ready/s_number: one signed number per item. With a bad
//   alphabet (fewer than two chars, repeats, non-alphanumerics, no end
//   within 62 chars) the item is taken and produces nothing.
//   m_valid/m_ready/m_character/m_last_char: one character per item, an
//   optional '-' first, then digits MSB first; m_last_char marks the end.
// Timing:
//   The divider retires 8 quotient bits a cycle; each digit of a 32-bit
//   number takes a full pass of the divider over all its bits, and the
//   characters then leave one per cycle while m_ready is high. One number
//   is converted at a time; a two-entry queue lets the front take the next
//   items while the back works.
// Reset: alphabet clears to all zero (invalid), queue and output empty.
// Stall: a low m_ready holds the output register and the back waits; the
//   queue fills and then s_ready drops.
// ============================================================================
module radix_digit_emitter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rde_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [rde_pkg::NUMBER_WIDTH-1:0] s_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rde_pkg::CHAR_W-1:0]    m_character,
    output logic                          m_last_char
);
    import rde_pkg::*;

    rde_alpha_t       alpha;       // alphabet contents and check result
    rde_item_t        push_data;   // front -> queue
    rde_item_t        pop_data;    // queue -> back
    rde_back_status_t back_status;
    logic             push_valid;
    logic             push_ready;
    logic             pop_valid;
    logic             pop_ready;

    // front: config, alphabet check, sign/magnitude split
    rde_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_number   (s_number),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .alpha      (alpha)
    );

    // decouples acceptance from conversion
    rde_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: division loop, digit buffer, character output
    rde_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .alpha       (alpha),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char),
        .status      (back_status)
    );

`ifndef ASSERT_OFF
    // a config write starts the alphabet check, which blocks input
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("input taken during alphabet check");

    // a minus sign is never the final character
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_character == CHAR_MINUS[CHAR_W-1:0]) |-> !m_last_char)
        else $error("minus sign flagged last");

    // nothing queued, nothing converting, nothing shown: no result appears
    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!back_status.busy && !pop_valid && !m_valid) |=> !m_valid)
        else $error("result appeared with no work pending");
`endif

endmodule

>>> src/rde_front.sv
// ============================================================================
// rde_front - alphabet registers, alphabet check, item classification
// Holds the config words, checks the alphabet one byte per cycle after each
// write, and splits each accepted number into sign and magnitude.
// ============================================================================
module rde_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rde_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [rde_pkg::NUMBER_WIDTH-1:0] s_number,
    output logic                          push_valid,
    input  logic                          push_ready,
    output rde_pkg::rde_item_t            push_data,
    output rde_pkg::rde_alpha_t           alpha
);
    import rde_pkg::*;

    logic [ALPHA_WORDS-1:0][CFG_W-1:0] alpha_reg;
    logic                          busy_reg;
    logic [ALPHA_IDX_W-1:0]        idx_reg;
    logic [ALNUM_COUNT-1:0]        seen_reg;
    logic                          valid_reg;
    logic [RADIX_W-1:0]            radix_reg;

    logic [7:0]              cur_byte;
    logic [ALNUM_CODE_W-1:0] cur_code;
    logic [NUMBER_WIDTH-1:0] num_u;

    assign cur_byte = alpha_byte(alpha_reg, idx_reg);
    assign cur_code = alnum_code(cur_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            seen_reg  <= '0;
            valid_reg <= 1'b0;
            radix_reg <= '0;
        end else if (cfg_we) begin
            alpha_reg[cfg_index] <= cfg_wdata;
            busy_reg  <= 1'b1;
            idx_reg   <= '0;
            seen_reg  <= '0;
            valid_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cur_byte == CHAR_NUL) begin
                // terminator found: length is the radix
                busy_reg  <= 1'b0;
                valid_reg <= (idx_reg >= ALPHA_IDX_W'(2));
                radix_reg <= RADIX_W'(idx_reg);
            end else if (idx_reg == ALPHA_IDX_W'(MAX_ALPHABET)) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b0;
            end else if (!is_alnum(cur_byte) || seen_reg[cur_code]) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b0;
            end else begin
                seen_reg[cur_code] <= 1'b1;
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign num_u          = NUMBER_WIDTH'(s_number);
    assign s_ready        = !busy_reg && push_ready;
    // with a bad alphabet the item is taken and dropped
    assign push_valid     = s_valid && s_ready && valid_reg;
    assign push_data.neg  = num_u[NUMBER_WIDTH-1];
    assign push_data.mag  = num_u[NUMBER_WIDTH-1] ? (~num_u + 1'b1) : num_u;

    assign alpha.valid = valid_reg;
    assign alpha.radix = radix_reg;
    assign alpha.bytes = alpha_reg;

endmodule

>>> src/rde_queue.sv
// ============================================================================
// rde_queue - short item queue between front and back
// Register FIFO; ready and valid come straight from the fill count.
// ============================================================================
module rde_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  rde_pkg::rde_item_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output rde_pkg::rde_item_t pop_data
);
    import rde_pkg::*;

    rde_item_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_reg;
    logic [QUEUE_PTR_W-1:0] rd_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/rde_back.sv
// ============================================================================
// rde_back - digit generation and character output
// Sends any '-' first, divides the magnitude by the radix 8 bits a cycle
// storing digits LSB first, then emits them MSB first via an output register.
// ============================================================================
module rde_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rde_pkg::rde_alpha_t       alpha,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  rde_pkg::rde_item_t        pop_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [rde_pkg::CHAR_W-1:0] m_character,
    output logic                      m_last_char,
    output rde_pkg::rde_back_status_t status
);
    import rde_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [DIV_PAD_W-1:0]   div_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [DIG_IDX_W-1:0]   cnt_reg;
    logic                   m_valid_reg;
    logic [CHAR_W-1:0]      m_char_reg;
    logic                   m_last_reg;
    logic [DIGIT_W-1:0]     buf_reg [MAX_DIGITS];

    logic [DIV_PAD_W-1:0]   div_next;
    logic [RADIX_W-1:0]     rem_next;
    logic                   out_free;
    logic                   digit_done;
    logic [7:0]             emit_byte;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        logic [DIV_PAD_W-1:0] d;
        logic [RADIX_W-1:0]   r;
        logic [RADIX_W:0]     trial;
        logic [RADIX_W:0]     diff;
        d = div_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {r, d[DIV_PAD_W-1]};
            d     = {d[DIV_PAD_W-2:0], 1'b0};
            diff  = trial - {1'b0, alpha.radix};
            if (trial >= {1'b0, alpha.radix}) begin
                r    = diff[RADIX_W-1:0];
                d[0] = 1'b1;
            end else begin
                r = trial[RADIX_W-1:0];
            end
        end
        div_next = d;
        rem_next = r;
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign digit_done = (state_reg == ST_DIV) && (step_reg == STEP_W'(DIV_STEPS - 1));
    assign emit_byte  = alpha_byte(alpha.bytes, ALPHA_IDX_W'(buf_reg[cnt_reg]));
    assign pop_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (digit_done) begin
            buf_reg[cnt_reg] <= rem_next[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            cnt_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        div_reg   <= DIV_PAD_W'(pop_data.mag);
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= pop_data.neg ? ST_SIGN : ST_DIV;
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_char_reg  <= CHAR_MINUS[CHAR_W-1:0];
                        m_last_reg  <= 1'b0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    div_reg <= div_next;
                    if (digit_done) begin
                        rem_reg  <= '0;
                        step_reg <= '0;
                        // zero magnitude still yields one digit
                        if (div_next == '0 || cnt_reg == DIG_IDX_W'(MAX_DIGITS - 1)) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end else begin
                        rem_reg  <= rem_next;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_char_reg  <= emit_byte[CHAR_W-1:0];
                        m_last_reg  <= (cnt_reg == '0);
                        if (cnt_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last_char = m_last_reg;
    assign status.busy = (state_reg != ST_IDLE);

endmodule
